// ----- design/http_header_span_tokenizer_unit_assert.svh -----
// Assertion macros for the HTTP header span tokenizer checker.
// Included by files that hold concurrent assertions; depends on nothing else.
`ifndef HTTP_HEADER_SPAN_TOKENIZER_UNIT_ASSERT_SVH
`define HTTP_HEADER_SPAN_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define HHST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhst assertion failed");

// Next-cycle implication, checked while out of reset.
`define HHST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhst assertion failed");

`endif

// ----- design/hhst_pkg.sv -----
// Shared types and constants for the HTTP header span tokenizer.
// Used by the front end, job queue, back end, top level and checker.
`default_nettype none

package hhst_pkg;

  localparam int unsigned MAX_BUFFER_BYTES = 65535;
  localparam int unsigned START_TOKENS     = 3;
  localparam int unsigned JOB_DEPTH        = 4;

  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  typedef enum logic [2:0] {
    REC_HEADER   = 3'd0,
    REC_METHOD   = 3'd1,
    REC_URI      = 3'd2,
    REC_PROTOCOL = 3'd3,
    REC_SUMMARY  = 3'd4
  } rec_kind_e;

  // One unit of work from the front end: an optional header-line record and,
  // on the final byte, a snapshot of the start-line tokens and the summary.
  typedef struct packed {
    logic             has_hdr;
    logic             has_final;
    logic [15:0]      key_start;
    logic [15:0]      key_length;
    logic [15:0]      val_start;
    logic [15:0]      val_length;
    logic [2:0][15:0] tok_start;
    logic [2:0][15:0] tok_length;
    logic [15:0]      hdr_length;
    logic             too_long;
  } job_t;

endpackage

`default_nettype wire

// ----- design/hhst_front.sv -----
// Front end: byte-by-byte parser state and job generation.
// Depends on hhst_pkg.
`default_nettype none

module hhst_front
  import hhst_pkg::*;
#(
  parameter int unsigned MaxBufferBytes = MAX_BUFFER_BYTES,
  parameter int unsigned StartTokens    = START_TOKENS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       job_wr_o,
  output job_t       job_o
);

  localparam logic [15:0] OffsetCap =
    (MaxBufferBytes < 65535) ? 16'(MaxBufferBytes) : 16'hFFFF;
  localparam logic [1:0] LastTok = 2'(StartTokens - 1);

  typedef enum logic [2:0] {
    PH_SKIP_TOK  = 3'd0,
    PH_IN_TOK    = 3'd1,
    PH_IN_NAME   = 3'd2,
    PH_SKIP_VAL  = 3'd3,
    PH_IN_VAL    = 3'd4
  } phase_e;

  typedef struct packed {
    logic        hit;
    logic [15:0] value;
  } sat_t;

  function automatic sat_t sat_inc(logic [15:0] v);
    sat_t r;
    r.hit   = (v >= OffsetCap);
    r.value = r.hit ? OffsetCap : v + 16'd1;
    return r;
  endfunction

  phase_e           phase_q, phase_d;
  logic [1:0]       tok_num_q, tok_num_d;
  logic [15:0]      offset_q, offset_d;
  logic [7:0]       prev_q, prev_d;
  logic [2:0][15:0] tok_start_q, tok_start_d;
  logic [2:0][15:0] tok_len_q, tok_len_d;
  logic [15:0]      name_start_q, name_start_d;
  logic [15:0]      name_len_q, name_len_d;
  logic [15:0]      val_start_q, val_start_d;
  logic [15:0]      val_len_q, val_len_d;
  logic [15:0]      hdr_bytes_q, hdr_bytes_d;
  logic             finished_q, finished_d;
  logic             sat_q, sat_d;

  logic        rec_valid;
  logic [15:0] rec_val_len;
  sat_t        off_inc, tok_inc, name_inc, val_inc;
  logic        hit;

  always_comb begin
    phase_d      = phase_q;
    tok_num_d    = tok_num_q;
    offset_d     = offset_q;
    prev_d       = prev_q;
    tok_start_d  = tok_start_q;
    tok_len_d    = tok_len_q;
    name_start_d = name_start_q;
    name_len_d   = name_len_q;
    val_start_d  = val_start_q;
    val_len_d    = val_len_q;
    hdr_bytes_d  = hdr_bytes_q;
    finished_d   = finished_q;
    rec_valid    = 1'b0;
    rec_val_len  = '0;
    hit          = 1'b0;

    off_inc  = sat_inc(offset_q);
    tok_inc  = sat_inc(tok_len_q[tok_num_q]);
    name_inc = sat_inc(name_len_q);
    val_inc  = sat_inc(val_len_q);

    if (!finished_q) begin
      unique case (phase_q)
        PH_SKIP_TOK: begin
          if (data_byte_i != CHAR_SP) begin
            phase_d                = PH_IN_TOK;
            tok_start_d[tok_num_q] = offset_q;
            tok_len_d[tok_num_q]   = '0;
          end
        end
        PH_IN_TOK: begin
          tok_len_d[tok_num_q] = tok_inc.value;
          hit                  = tok_inc.hit;
          if (data_byte_i == CHAR_SP) begin
            // Only the last token may swallow further spaces.
            if (tok_num_q < LastTok) begin
              phase_d   = PH_SKIP_TOK;
              tok_num_d = tok_num_q + 2'd1;
            end
          end else if (data_byte_i == CHAR_LF) begin
            if (tok_inc.value != '0 && prev_q == CHAR_CR) begin
              tok_len_d[tok_num_q] = tok_inc.value - 16'd1;
            end
            name_start_d = off_inc.value;
            name_len_d   = '0;
            hdr_bytes_d  = off_inc.value;
            hit          = hit | off_inc.hit;
            phase_d      = PH_IN_NAME;
          end
        end
        PH_IN_NAME: begin
          if (data_byte_i == CHAR_COLON) begin
            phase_d = PH_SKIP_VAL;
          end else if (data_byte_i == CHAR_LF) begin
            hdr_bytes_d = off_inc.value;
            hit         = off_inc.hit;
            finished_d  = 1'b1;
          end else begin
            name_len_d = name_inc.value;
            hit        = name_inc.hit;
          end
        end
        PH_SKIP_VAL: begin
          if (data_byte_i != CHAR_SP) begin
            val_start_d = offset_q;
            val_len_d   = '0;
            phase_d     = PH_IN_VAL;
          end
        end
        default: begin
          val_len_d = val_inc.value;
          hit       = val_inc.hit;
          if (data_byte_i == CHAR_LF) begin
            rec_val_len = val_inc.value;
            if (val_inc.value != '0 && prev_q == CHAR_CR) begin
              rec_val_len = val_inc.value - 16'd1;
            end
            val_len_d    = rec_val_len;
            rec_valid    = 1'b1;
            name_start_d = off_inc.value;
            name_len_d   = '0;
            hit          = hit | off_inc.hit;
            phase_d      = PH_IN_NAME;
          end
        end
      endcase
      prev_d   = data_byte_i;
      offset_d = off_inc.value;
      hit      = hit | off_inc.hit;
    end
    sat_d = sat_q | hit;
  end

  always_comb begin
    job_o.has_hdr    = rec_valid;
    job_o.has_final  = final_byte_i;
    job_o.key_start  = name_start_q;
    job_o.key_length = name_len_q;
    job_o.val_start  = val_start_q;
    job_o.val_length = rec_val_len;
    job_o.tok_start  = tok_start_d;
    job_o.tok_length = tok_len_d;
    job_o.hdr_length = (tok_len_d[0] == '0 || tok_len_d[1] == '0) ? '0 : hdr_bytes_d;
    job_o.too_long   = sat_d;
    job_wr_o         = accept_i && (rec_valid || final_byte_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SKIP_TOK;
      tok_num_q    <= '0;
      offset_q     <= '0;
      prev_q       <= '0;
      tok_start_q  <= '0;
      tok_len_q    <= '0;
      name_start_q <= '0;
      name_len_q   <= '0;
      val_start_q  <= '0;
      val_len_q    <= '0;
      hdr_bytes_q  <= '0;
      finished_q   <= 1'b0;
      sat_q        <= 1'b0;
    end else if (accept_i) begin
      if (final_byte_i) begin
        // The final byte of a buffer returns the parser to its idle state.
        phase_q      <= PH_SKIP_TOK;
        tok_num_q    <= '0;
        offset_q     <= '0;
        prev_q       <= '0;
        tok_start_q  <= '0;
        tok_len_q    <= '0;
        name_start_q <= '0;
        name_len_q   <= '0;
        val_start_q  <= '0;
        val_len_q    <= '0;
        hdr_bytes_q  <= '0;
        finished_q   <= 1'b0;
        sat_q        <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        tok_num_q    <= tok_num_d;
        offset_q     <= offset_d;
        prev_q       <= prev_d;
        tok_start_q  <= tok_start_d;
        tok_len_q    <= tok_len_d;
        name_start_q <= name_start_d;
        name_len_q   <= name_len_d;
        val_start_q  <= val_start_d;
        val_len_q    <= val_len_d;
        hdr_bytes_q  <= hdr_bytes_d;
        finished_q   <= finished_d;
        sat_q        <= sat_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/hhst_jobq.sv -----
// Short job queue between the parser front end and the record back end.
// Depends on hhst_pkg.
`default_nettype none

module hhst_jobq
  import hhst_pkg::*;
#(
  parameter int unsigned Depth = JOB_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_job_i,
  output logic full_o,
  input  logic rd_i,
  output logic valid_o,
  output job_t rd_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o   = (count_q == (PtrW + 1)'(Depth));
  assign valid_o  = (count_q != '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (PtrW + 1)'(wr_i) - (PtrW + 1)'(rd_i);
    end
  end

endmodule

`default_nettype wire

// ----- design/hhst_back.sv -----
// Back end: expands queued jobs into span records in the output register, one per
// cycle while that register is empty or popped. Depends on hhst_pkg.
`default_nettype none

module hhst_back
  import hhst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_rd_o,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  record_kind_o,
  output logic [15:0] key_start_o,
  output logic [15:0] key_length_o,
  output logic [15:0] span_start_o,
  output logic [15:0] span_length_o,
  output logic [15:0] header_length_o,
  output logic        too_long_o,
  output logic        run_end_o
);

  rec_kind_e   step_q, step_d, cur;
  logic        out_valid_q;
  logic        load, last_rec;
  logic [2:0]  kind_q;
  logic [15:0] ks_q, kl_q, ss_q, sl_q, hl_q;
  logic        tl_q, re_q;
  logic [15:0] ks_d, kl_d, ss_d, sl_d, hl_d;
  logic        tl_d;

  assign load = job_valid_i && (!out_valid_q || pop);

  always_comb begin
    // A job without a header record starts straight at the method record.
    cur = (step_q == REC_HEADER && !job_i.has_hdr) ? REC_METHOD : step_q;
    last_rec = (cur == REC_HEADER && !job_i.has_final) || cur == REC_SUMMARY;
    step_d = last_rec ? REC_HEADER : rec_kind_e'(cur + 3'd1);
    ks_d = '0;
    kl_d = '0;
    ss_d = '0;
    sl_d = '0;
    hl_d = '0;
    tl_d = 1'b0;
    unique case (cur)
      REC_HEADER: begin
        ks_d = job_i.key_start;
        kl_d = job_i.key_length;
        ss_d = job_i.val_start;
        sl_d = job_i.val_length;
      end
      REC_METHOD: begin
        ss_d = job_i.tok_start[0];
        sl_d = job_i.tok_length[0];
      end
      REC_URI: begin
        ss_d = job_i.tok_start[1];
        sl_d = job_i.tok_length[1];
      end
      REC_PROTOCOL: begin
        ss_d = job_i.tok_start[2];
        sl_d = job_i.tok_length[2];
      end
      REC_SUMMARY: begin
        hl_d = job_i.hdr_length;
        tl_d = job_i.too_long;
      end
      default: begin
        hl_d = '0;
      end
    endcase
  end

  assign job_rd_o = load && last_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= REC_HEADER;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q <= step_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= cur;
      ks_q   <= ks_d;
      kl_q   <= kl_d;
      ss_q   <= ss_d;
      sl_q   <= sl_d;
      hl_q   <= hl_d;
      tl_q   <= tl_d;
      re_q   <= last_rec;
    end
  end

  assign empty           = !out_valid_q;
  assign record_kind_o   = kind_q;
  assign key_start_o     = ks_q;
  assign key_length_o    = kl_q;
  assign span_start_o    = ss_q;
  assign span_length_o   = sl_q;
  assign header_length_o = hl_q;
  assign too_long_o      = tl_q;
  assign run_end_o       = re_q;

endmodule

`default_nettype wire

// ----- design/http_header_span_tokenizer_unit.sv -----
// A job enters the job queue and is expanded into the back end's output register.
// Throughput: one byte per cycle while full is low; a final byte expands into four or five
// records that leave one per cycle while popped, absorbed by a four-entry job queue before full rises.
// Reset: asynchronous, active low; parser, queue and output valid flag clear at once.
// Top level of the HTTP header span tokenizer; depends on hhst_pkg, hhst_front,
// hhst_jobq and hhst_back.
`default_nettype none

module http_header_span_tokenizer_unit
  import hhst_pkg::*;
#(
  parameter int unsigned MaxBufferBytes = MAX_BUFFER_BYTES,
  parameter int unsigned StartTokens    = START_TOKENS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  record_kind_o,
  output logic [15:0] key_start_o,
  output logic [15:0] key_length_o,
  output logic [15:0] span_start_o,
  output logic [15:0] span_length_o,
  output logic [15:0] header_length_o,
  output logic        too_long_o,
  output logic        run_end_o
);

  logic accept;
  logic job_wr, job_rd, job_valid;
  job_t wr_job, rd_job;

  assign accept = push && !full;

  hhst_front #(
    .MaxBufferBytes(MaxBufferBytes),
    .StartTokens   (StartTokens)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .final_byte_i(final_byte_i),
    .job_wr_o    (job_wr),
    .job_o       (wr_job)
  );

  hhst_jobq #(
    .Depth(JOB_DEPTH)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wr_job_i(wr_job),
    .full_o  (full),
    .rd_i    (job_rd),
    .valid_o (job_valid),
    .rd_job_o(rd_job)
  );

  hhst_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (rd_job),
    .job_rd_o       (job_rd),
    .pop            (pop),
    .empty          (empty),
    .record_kind_o  (record_kind_o),
    .key_start_o    (key_start_o),
    .key_length_o   (key_length_o),
    .span_start_o   (span_start_o),
    .span_length_o  (span_length_o),
    .header_length_o(header_length_o),
    .too_long_o     (too_long_o),
    .run_end_o      (run_end_o)
  );

endmodule

`default_nettype wire

// ----- design/hhst_checker.sv -----
// Port-level checker for the HTTP header span tokenizer, bound to the top level.
// Depends on hhst_pkg and the assertion macro header.
`default_nettype none
`include "http_header_span_tokenizer_unit_assert.svh"

module hhst_checker
  import hhst_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  record_kind_o,
  input logic [15:0] key_start_o,
  input logic [15:0] key_length_o,
  input logic [15:0] span_start_o,
  input logic [15:0] span_length_o,
  input logic [15:0] header_length_o,
  input logic        too_long_o,
  input logic        run_end_o
);

  // A waiting record must not change until it is taken.
  `HHST_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(record_kind_o) && $stable(span_start_o) && $stable(span_length_o) && $stable(run_end_o))

  // Only header-line records carry a key span.
  `HHST_ASSERT_NOW(a_key_zero, clk_i, rst_ni, !empty && record_kind_o != REC_HEADER, key_start_o == '0 && key_length_o == '0)

  // Header length and the saturation flag belong to the summary alone.
  `HHST_ASSERT_NOW(a_sum_only, clk_i, rst_ni, !empty && record_kind_o != REC_SUMMARY, header_length_o == '0 && !too_long_o)

  // The summary closes every final-byte run.
  `HHST_ASSERT_NOW(a_sum_end, clk_i, rst_ni, !empty && record_kind_o == REC_SUMMARY, run_end_o)

  // Token records are always followed by more records of the same run.
  `HHST_ASSERT_NOW(a_tok_mid, clk_i, rst_ni, !empty && (record_kind_o == REC_METHOD || record_kind_o == REC_URI || record_kind_o == REC_PROTOCOL), !run_end_o)

endmodule

bind http_header_span_tokenizer_unit hhst_checker u_hhst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .record_kind_o  (record_kind_o),
  .key_start_o    (key_start_o),
  .key_length_o   (key_length_o),
  .span_start_o   (span_start_o),
  .span_length_o  (span_length_o),
  .header_length_o(header_length_o),
  .too_long_o     (too_long_o),
  .run_end_o      (run_end_o)
);

`default_nettype wire
